FILE: src/vlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlm_pkg
// Shared types and constants of the voxel LRU map.
// ----------------------------------------------------------------------------
package vlm_pkg;

  localparam int unsigned PointW   = 32;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned LimitW   = 11;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegScale = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLimit = 1'b1;

  localparam logic [ScaleW-1:0] ScaleReset = 16'd256;
  localparam logic [LimitW-1:0] LimitReset = 11'd1024;

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_MUL    = 15'b000000000000100,
    ST_SAT    = 15'b000000000001000,
    ST_SCAN   = 15'b000000000010000,
    ST_SCANE  = 15'b000000000100000,
    ST_DECIDE = 15'b000000001000000,
    ST_LINKRD = 15'b000000010000000,
    ST_HIT1   = 15'b000000100000000,
    ST_HIT2   = 15'b000001000000000,
    ST_HIT3   = 15'b000010000000000,
    ST_MISS1  = 15'b000100000000000,
    ST_MISS2  = 15'b001000000000000,
    ST_EVRD   = 15'b010000000000000,
    ST_EVWR   = 15'b100000000000000
  } state_e;

endpackage

FILE: src/vlm_key_quant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlm_key_quant
// Scales one Q16.16 coordinate by a Q8.8 factor, truncates toward zero and
// saturates to a signed key component. Two register stages.
// ----------------------------------------------------------------------------
module vlm_key_quant #(
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic signed [vlm_pkg::PointW-1:0]   point_i,
  input  logic        [vlm_pkg::ScaleW-1:0]   scale_i,
  output logic signed [KEY_BITS-1:0]          key_o
);
  import vlm_pkg::*;

  localparam int unsigned ProdW = PointW + ScaleW;
  localparam int unsigned QW    = ProdW - 24;
  localparam logic [QW:0] PosMax = (QW+1)'((64'd1 << (KEY_BITS - 1)) - 64'd1);
  localparam logic [QW:0] NegMax = (QW+1)'(64'd1 << (KEY_BITS - 1));

  logic [PointW-1:0] mag;
  logic [ProdW-1:0]  prod_d, prod_q;
  logic              neg_q;
  logic [QW:0]       q;
  logic [QW:0]       sat;
  logic signed [KEY_BITS-1:0] key_d, key_q;

  assign mag    = point_i[PointW-1] ? (~point_i + 1'b1) : point_i;
  assign prod_d = ProdW'(mag) * ProdW'(scale_i);
  assign q      = {1'b0, prod_q[ProdW-1:24]};

  always_comb begin
    if (neg_q) begin
      sat   = (q > NegMax) ? NegMax : q;
      key_d = KEY_BITS'(~sat + 1'b1);
    end else begin
      sat   = (q > PosMax) ? PosMax : q;
      key_d = KEY_BITS'(sat);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= point_i[PointW-1];
    key_q  <= key_d;
  end

  assign key_o = key_q;

endmodule

FILE: src/voxel_lru_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_lru_map_core
// Voxel key table with least-recently-used eviction.
// ----------------------------------------------------------------------------
// Each point beat is quantized to a voxel key, which is looked up in a table
// of TABLE_DEPTH slots held in one key memory and two link memories. The
// lookup reads the key memory one slot per cycle and scans it in full for
// every item; a new point is taken only once the last one is done. After
// reset the block clears the valid bits of every slot and takes no point
// until that is done. Configuration writes are taken at any time but must
// only happen while the block is idle.
module voxel_lru_map_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vlm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [vlm_pkg::ScaleW-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_x, point_y, point_z
  input  logic [vlm_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // was_hit, slot_index, voxel_x, voxel_y, voxel_z, did_evict,
  // evicted_x, evicted_y, evicted_z, zero padding
  output logic [vlm_pkg::OutDataW-1:0]      m_axis_tdata
);
  import vlm_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned OW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW  = 3 * KEY_BITS;
  localparam int unsigned MW  = KW + 1;
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);
  localparam logic [31:0]   Depth32  = 32'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [ScaleW-1:0] scale_q;
  logic [LimitW-1:0] limit_q;

  logic signed [PointW-1:0] px_q, py_q, pz_q;
  logic signed [KEY_BITS-1:0] kx, ky, kz;
  logic [KW-1:0] key;

  logic [MW-1:0] key_mem [TABLE_DEPTH];
  logic [AW-1:0] nwr_mem [TABLE_DEPTH];
  logic [AW-1:0] old_mem [TABLE_DEPTH];

  logic          key_we, nwr_we, old_we;
  logic [AW-1:0] key_wa, nwr_wa, old_wa, key_ra, nwr_ra, old_ra;
  logic [MW-1:0] key_wd, key_rd_q;
  logic [AW-1:0] nwr_wd, old_wd, nwr_rd_q, old_rd_q;

  logic [AW-1:0] cnt_q;
  logic          cmp_vld_q;
  logic [AW-1:0] cmp_idx_q;
  logic          hit_q, free_fnd_q, evict_q;
  logic [AW-1:0] hit_slot_q, free_q, front_q, back_q, nw_q;
  logic [OW-1:0] occ_q;
  logic [KW-1:0] ev_key_q;
  logic          out_vld_q;
  logic [OutDataW-1:0] out_q;
  logic          is_back, ev_front, occ_zero, ev_need;
  logic          in_acc;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign key           = {kz, ky, kx};
  assign is_back       = (hit_slot_q == back_q);
  assign ev_front      = (back_q == front_q);
  assign occ_zero      = (occ_q == '0);
  assign ev_need       = (32'(occ_q) >= 32'(limit_q)) || (32'(occ_q) >= Depth32);

  vlm_key_quant #(.KEY_BITS(KEY_BITS)) u_qx (
    .clk_i(clk_i), .point_i(px_q), .scale_i(scale_q), .key_o(kx));
  vlm_key_quant #(.KEY_BITS(KEY_BITS)) u_qy (
    .clk_i(clk_i), .point_i(py_q), .scale_i(scale_q), .key_o(ky));
  vlm_key_quant #(.KEY_BITS(KEY_BITS)) u_qz (
    .clk_i(clk_i), .point_i(pz_q), .scale_i(scale_q), .key_o(kz));

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nwr_we) begin
      nwr_mem[nwr_wa] <= nwr_wd;
    end
    nwr_rd_q <= nwr_mem[nwr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (old_we) begin
      old_mem[old_wa] <= old_wd;
    end
    old_rd_q <= old_mem[old_ra];
  end

  always_comb begin
    key_we = 1'b0;
    key_wa = free_q;
    key_wd = {1'b1, key};
    key_ra = cnt_q;
    nwr_we = 1'b0;
    nwr_wa = hit_slot_q;
    nwr_wd = hit_slot_q;
    nwr_ra = hit_slot_q;
    old_we = 1'b0;
    old_wa = hit_slot_q;
    old_wd = front_q;
    old_ra = hit_slot_q;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        key_we = 1'b1;
        key_wa = cnt_q;
        key_wd = '0;
        if (cnt_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_SAT;
      ST_SAT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (cnt_q == LastSlot) begin
          state_d = ST_SCANE;
        end
      end
      ST_SCANE: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!hit_q) begin
          state_d = ST_MISS1;
        end else if (hit_slot_q == front_q) begin
          state_d = ST_EVWR;
        end else begin
          state_d = ST_LINKRD;
        end
      end
      ST_LINKRD: state_d = ST_HIT1;
      ST_HIT1: begin
        old_we = 1'b1;
        old_wa = nwr_rd_q;
        old_wd = is_back ? nwr_rd_q : old_rd_q;
        nwr_we = !is_back;
        nwr_wa = old_rd_q;
        nwr_wd = nwr_rd_q;
        state_d = ST_HIT2;
      end
      ST_HIT2: begin
        nwr_we = 1'b1;
        old_we = 1'b1;
        state_d = ST_HIT3;
      end
      ST_HIT3: begin
        nwr_we = 1'b1;
        nwr_wa = front_q;
        state_d = ST_EVWR;
      end
      ST_MISS1: begin
        key_we = 1'b1;
        nwr_we = 1'b1;
        nwr_wa = free_q;
        nwr_wd = free_q;
        old_we = 1'b1;
        old_wa = free_q;
        old_wd = occ_zero ? free_q : front_q;
        state_d = ST_MISS2;
      end
      ST_MISS2: begin
        nwr_we = !occ_zero;
        nwr_wa = front_q;
        nwr_wd = free_q;
        state_d = ST_EVRD;
      end
      ST_EVRD: begin
        key_ra = back_q;
        nwr_ra = back_q;
        state_d = ST_EVWR;
      end
      ST_EVWR: begin
        key_ra = back_q;
        nwr_ra = back_q;
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_IDLE;
          if (evict_q) begin
            key_we = 1'b1;
            key_wa = back_q;
            key_wd = {1'b0, key_rd_q[KW-1:0]};
            old_we = !ev_front;
            old_wa = nwr_rd_q;
            old_wd = nwr_rd_q;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      scale_q    <= ScaleReset;
      limit_q    <= LimitReset;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
      evict_q    <= 1'b0;
      front_q    <= '0;
      back_q     <= '0;
      occ_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegScale: scale_q <= cfg_data_i;
          RegLimit: limit_q <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_EVWR && state_d == ST_IDLE) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: cnt_q <= cnt_q + 1'b1;
        ST_IDLE: begin
          cnt_q      <= '0;
          hit_q      <= 1'b0;
          free_fnd_q <= 1'b0;
          evict_q    <= 1'b0;
        end
        ST_SCAN: cnt_q <= cnt_q + 1'b1;
        ST_HIT3: begin
          front_q <= hit_slot_q;
          if (is_back) begin
            back_q <= nw_q;
          end
        end
        ST_MISS2: begin
          front_q <= free_q;
          if (occ_zero) begin
            back_q <= free_q;
          end
          occ_q <= occ_q + 1'b1;
        end
        ST_EVRD: evict_q <= ev_need;
        ST_EVWR: begin
          if (state_d == ST_IDLE && evict_q) begin
            if (!ev_front) begin
              back_q <= nwr_rd_q;
            end
            occ_q <= occ_q - 1'b1;
          end
        end
        default: ;
      endcase
      if (cmp_vld_q) begin
        if (key_rd_q[KW] && key_rd_q[KW-1:0] == key) begin
          hit_q <= 1'b1;
        end
        if (!key_rd_q[KW] && !free_fnd_q) begin
          free_fnd_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q     <= s_axis_tdata[31:0];
      py_q     <= s_axis_tdata[63:32];
      pz_q     <= s_axis_tdata[95:64];
      ev_key_q <= '0;
    end
    if (cmp_vld_q) begin
      if (key_rd_q[KW] && key_rd_q[KW-1:0] == key) begin
        hit_slot_q <= cmp_idx_q;
      end
      if (!key_rd_q[KW] && !free_fnd_q) begin
        free_q <= cmp_idx_q;
      end
    end
    cmp_idx_q <= cnt_q;
    if (state_q == ST_HIT1) begin
      nw_q <= nwr_rd_q;
    end
    if (state_q == ST_MISS1) begin
      hit_slot_q <= free_q;
    end
    if (state_q == ST_EVWR && evict_q) begin
      ev_key_q <= key_rd_q[KW-1:0];
    end
    if (state_q == ST_EVWR && state_d == ST_IDLE) begin
      out_q <= {4'b0000,
                FieldW'($signed(evict_q ? key_rd_q[3*KEY_BITS-1:2*KEY_BITS]
                                        : ev_key_q[3*KEY_BITS-1:2*KEY_BITS])),
                FieldW'($signed(evict_q ? key_rd_q[2*KEY_BITS-1:KEY_BITS]
                                        : ev_key_q[2*KEY_BITS-1:KEY_BITS])),
                FieldW'($signed(evict_q ? key_rd_q[KEY_BITS-1:0]
                                        : ev_key_q[KEY_BITS-1:0])),
                evict_q,
                FieldW'(kz), FieldW'(ky), FieldW'(kx),
                SlotW'(hit_slot_q),
                hit_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= Depth32)
    else $error("occupancy above table depth");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[59])
    else $error("hit beat reports an eviction");

  a_no_evict_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[59] |-> m_axis_tdata[107:60] == '0)
    else $error("evicted key not zero without eviction");

  a_occ_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && $past(state_q) == ST_IDLE |-> $stable(occ_q))
    else $error("occupancy changed while idle");

endmodule

FILE: dv/tb_voxel_lru_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_lru_map_core
// Self-checking testbench of the voxel LRU map core.
// ----------------------------------------------------------------------------
// A table of directed rows, made of point beats and register writes, runs
// first. Random phases with several scale and limit settings follow, mostly
// on a small cluster of voxels so that hits and evictions are frequent. A
// behavioral copy of the table predicts each result beat that a directed row
// does not give itself; every beat is compared field by field. Both stream
// sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_voxel_lru_map_core;
  import vlm_pkg::*;

  localparam int Depth = 1024;
  localparam int WatchLimit = 8000;

  typedef struct packed {
    logic        was_hit;
    logic [9:0]  slot;
    logic [15:0] vx, vy, vz;
    logic        did_evict;
    logic [15:0] ex, ey, ez;
  } voxel_result_t;

  typedef struct {
    bit             is_reg;
    logic [0:0]     reg_idx;
    logic [15:0]    reg_val;
    logic [31:0]    px, py, pz;
    bit             typed;
    voxel_result_t  res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegScale;
  logic [ScaleW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  voxel_lru_map_core dut (.*);

  always #6 clk_i = ~clk_i;

  // Table copy used for prediction.
  logic [15:0] scale_q;
  logic [10:0] limit_q;
  logic [47:0] key_mem [Depth];
  bit          slot_used [Depth];
  int unsigned newer_of [Depth];
  int unsigned older_of [Depth];
  int unsigned front_q, back_q, fill_q;

  voxel_result_t expected_q[$];
  int mismatches = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;
  int stall_cnt = 0;

  function automatic logic [15:0] voxel_key(logic [31:0] c);
    logic [32:0] mag;
    logic [48:0] q;
    mag = c[31] ? (33'h1_0000_0000 - {1'b0, c}) : {1'b0, c};
    q = (mag * scale_q) >> 24;
    if (c[31]) begin
      if (q > 49'd32768) q = 49'd32768;
      return 16'(-q);
    end
    if (q > 49'd32767) q = 49'd32767;
    return q[15:0];
  endfunction

  function automatic void detach(int unsigned s);
    int unsigned nw, od;
    bit at_front, at_back;
    nw = newer_of[s];
    od = older_of[s];
    at_front = (s == front_q);
    at_back = (s == back_q);
    if (at_front && !at_back) front_q = od;
    else if (at_back && !at_front) back_q = nw;
    else if (!at_front && !at_back) begin
      older_of[nw] = od;
      newer_of[od] = nw;
    end
    if (at_front && !at_back) newer_of[od] = od;
    if (at_back && !at_front) older_of[nw] = nw;
  endfunction

  function automatic void to_front(int unsigned s, int unsigned len);
    newer_of[s] = s;
    if (len == 0) begin
      older_of[s] = s;
      back_q = s;
    end else begin
      older_of[s] = front_q;
      newer_of[front_q] = s;
    end
    front_q = s;
  endfunction

  function automatic voxel_result_t lookup_voxel(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
    voxel_result_t r;
    logic [47:0] k;
    int unsigned lim, b;
    r = '0;
    k = {voxel_key(z), voxel_key(y), voxel_key(x)};
    lim = (limit_q > Depth) ? Depth : limit_q;
    r.vx = k[15:0];
    r.vy = k[31:16];
    r.vz = k[47:32];
    for (int s = 0; s < Depth; s++) begin
      if (slot_used[s] && key_mem[s] == k) begin
        r.was_hit = 1'b1;
        r.slot = 10'(s);
        break;
      end
    end
    if (r.was_hit) begin
      if (r.slot != front_q) begin
        detach(r.slot);
        to_front(r.slot, fill_q - 1);
      end
    end else begin
      for (int s = 0; s < Depth; s++) begin
        if (!slot_used[s]) begin
          r.slot = 10'(s);
          break;
        end
      end
      key_mem[r.slot] = k;
      slot_used[r.slot] = 1'b1;
      to_front(r.slot, fill_q);
      fill_q++;
      if (fill_q >= lim) begin
        b = back_q;
        r.did_evict = 1'b1;
        {r.ez, r.ey, r.ex} = key_mem[b];
        detach(b);
        slot_used[b] = 1'b0;
        fill_q--;
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegScale) scale_q = val;
    else limit_q = val[10:0];
  endtask

  task automatic drain();
    if (s_axis_tvalid) begin
      @(posedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit typed, voxel_result_t res);
    voxel_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tdata <= {z, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = lookup_voxel(x, y, z);
    expected_q.push_back(typed ? res : r);
  endtask

  function automatic logic [31:0] cluster_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
  endfunction

  always @(posedge clk_i) begin
    if (!quiet && stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    voxel_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.was_hit   = m_axis_tdata[0];
      got.slot      = m_axis_tdata[10:1];
      got.vx        = m_axis_tdata[26:11];
      got.vy        = m_axis_tdata[42:27];
      got.vz        = m_axis_tdata[58:43];
      got.did_evict = m_axis_tdata[59];
      got.ex        = m_axis_tdata[75:60];
      got.ey        = m_axis_tdata[91:76];
      got.ez        = m_axis_tdata[107:92];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got.was_hit !== want.was_hit || got.slot !== want.slot ||
            got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
            got.did_evict !== want.did_evict || got.ex !== want.ex ||
            got.ey !== want.ey || got.ez !== want.ez) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d slot=%0d key=%h,%h,%h ev=%0d %h,%h,%h",
                     want.was_hit, want.slot, want.vx, want.vy, want.vz,
                     want.did_evict, want.ex, want.ey, want.ez,
                     "\n          actual hit=%0d slot=%0d key=%h,%h,%h ev=%0d %h,%h,%h",
                     got.was_hit, got.slot, got.vx, got.vy, got.vz,
                     got.did_evict, got.ex, got.ey, got.ez);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic row_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    row_t r;
    r = '{default: '0};
    r.px = x;
    r.py = y;
    r.pz = z;
    return r;
  endfunction

  function automatic row_t pt_typed(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    voxel_result_t res);
    row_t r;
    r = pt(x, y, z);
    r.typed = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic row_t wr(logic [0:0] idx, logic [15:0] val);
    row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    int settings[8][2];
    settings = '{'{256, 4}, '{512, 16}, '{1, 2}, '{65535, 8},
                 '{0, 3}, '{128, 2047}, '{300, 5}, '{256, 32}};
    scale_q = ScaleReset;
    limit_q = LimitReset;
    front_q = 0;
    back_q = 0;
    fill_q = 0;
    for (int s = 0; s < Depth; s++) slot_used[s] = 1'b0;

    rows.push_back(pt_typed(32'h0, 32'h0, 32'h0, '{0, 10'd0, 0, 0, 0, 0, 0, 0, 0}));
    rows.push_back(pt_typed(32'h0, 32'h0, 32'h0, '{1, 10'd0, 0, 0, 0, 0, 0, 0, 0}));
    rows.push_back(pt_typed(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            '{0, 10'd1, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0}));
    rows.push_back(pt_typed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            '{0, 10'd2, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0}));
    rows.push_back(pt(32'hffff_8000, 32'h0000_8000, 32'hffff_0000));
    rows.push_back(pt(32'h0001_0000, 32'hfffe_ffff, 32'h1234_5678));
    rows.push_back(pt(32'h0, 32'h0, 32'h0));
    rows.push_back(wr(RegScale, 16'hffff));
    rows.push_back(pt(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000));
    rows.push_back(pt(32'h0000_0100, 32'hffff_ff00, 32'h0));
    rows.push_back(wr(RegScale, 16'h0000));
    rows.push_back(pt(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678));
    rows.push_back(wr(RegScale, 16'h0001));
    rows.push_back(wr(RegLimit, 16'd1));
    rows.push_back(pt(32'h0100_0000, 32'h0, 32'h0));
    rows.push_back(wr(RegLimit, 16'd0));
    rows.push_back(pt(32'h0200_0000, 32'h0, 32'h0));
    rows.push_back(wr(RegLimit, 16'd2));
    rows.push_back(pt(32'h0300_0000, 32'h0, 32'h0));
    rows.push_back(pt(32'h0400_0000, 32'h0, 32'h0));
    rows.push_back(pt(32'h0400_0000, 32'h0, 32'h0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        drain();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].typed, rows[i].res);
      end
    end

    foreach (settings[p]) begin
      drain();
      write_reg(RegScale, 16'(settings[p][0]));
      write_reg(RegLimit, 16'(settings[p][1]));
      if (p == 7) quiet = 1'b1;
      repeat (75) send_point(cluster_coord(), cluster_coord(), cluster_coord(), 1'b0, '0);
    end
    drain();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
